FILE: design/c3f_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c3f_pkg;

  // One pixel: blue in the low byte, then green, then red.
  typedef logic [23:0] pixel_t;

  localparam int CHAN_W    = 8;
  localparam int CHANNELS  = 3;
  localparam int TAPS      = 9;
  localparam int WIN_SIZE  = 3;
  localparam int MIN_DIM   = 3;
  localparam int CFG_DIM_W = 12;
  localparam int CHAN_MAX  = 255;

  // Channel sums stay within -2040..2295, so 14 signed bits leave headroom.
  localparam int SUM_W = 14;
  typedef logic signed [SUM_W-1:0] sum_t;

  // Kernel coefficients lie in -4..8.
  typedef logic signed [4:0] coef_t;

  typedef enum logic [2:0] {
    FILT_SMOOTH  = 3'd0,
    FILT_SHARPEN = 3'd1,
    FILT_EDGE    = 3'd2,
    FILT_EMBOSS  = 3'd3,
    FILT_OUTLINE = 3'd4
  } filter_t;

  localparam int FILTER_COUNT = 5;

  typedef enum logic [1:0] {
    REG_FILTER = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // Tap r*3+c weights window row r (oldest row first) and column c (oldest first).
  localparam coef_t KERNELS [FILTER_COUNT][TAPS] = '{
    '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
    '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
    '{ 5'sd0,  5'sd1,  5'sd0,  5'sd1, -5'sd4,  5'sd1,  5'sd0,  5'sd1,  5'sd0},
    '{ 5'sd2,  5'sd1,  5'sd0,  5'sd1,  5'sd1, -5'sd1,  5'sd0, -5'sd1, -5'sd2},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1}
  };

  // Division by nine for sums in 0..2295: floor(x * 7282 / 2^16) is exact there.
  localparam int DIV9_IN_W  = 12;
  localparam int RECIP_W    = 13;
  localparam int RECIP_NINE = 7282;
  localparam int DIV_SHIFT  = 16;

endpackage

`default_nettype wire

FILE: design/c3f_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module c3f_line_buf import c3f_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire pixel_t        wr_up1,
  input  wire pixel_t        wr_up2,
  output pixel_t             rd_up1,
  output pixel_t             rd_up2
);

  // Row above the current one, and the row above that.
  pixel_t store_a [DEPTH];
  pixel_t store_b [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_a[wr_addr] <= wr_up1;
      store_b[wr_addr] <= wr_up2;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_up1 <= store_a[rd_addr];
      rd_up2 <= store_b[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/c3f_window.sv
`timescale 1ns / 1ps
`default_nettype none

module c3f_window import c3f_pkg::*; (
  input  wire logic    clk,
  input  wire logic    shift_en,
  input  wire logic    load_en,
  input  wire pixel_t  px,
  input  wire pixel_t  up1,
  input  wire pixel_t  up2,
  input  wire filter_t sel,
  output sum_t         sums [CHANNELS]
);

  pixel_t win [TAPS];
  pixel_t win_next [TAPS];
  sum_t   sums_next [CHANNELS];

  always_comb begin
    for (int r = 0; r < WIN_SIZE; r++) begin
      win_next[r*WIN_SIZE]     = win[r*WIN_SIZE + 1];
      win_next[r*WIN_SIZE + 1] = win[r*WIN_SIZE + 2];
    end
    win_next[WIN_SIZE - 1]        = up2;
    win_next[2*WIN_SIZE - 1]      = up1;
    win_next[WIN_SIZE*WIN_SIZE-1] = px;
  end

  // The sums are taken over the window as it stands after this shift.
  always_comb begin
    logic signed [CHAN_W:0] pv;
    sum_t acc;
    for (int c = 0; c < CHANNELS; c++) begin
      acc = '0;
      for (int i = 0; i < TAPS; i++) begin
        pv  = signed'({1'b0, win_next[i][CHAN_W*c +: CHAN_W]});
        acc = acc + sum_t'(pv) * sum_t'(KERNELS[sel][i]);
      end
      sums_next[c] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win <= win_next;
    end
    if (load_en) begin
      sums <= sums_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/c3f_post.sv
`timescale 1ns / 1ps
`default_nettype none

module c3f_post import c3f_pkg::*; (
  input  wire logic    clk,
  input  wire logic    load,
  input  wire filter_t sel,
  input  wire sum_t    sums [CHANNELS],
  input  wire logic    last,
  output pixel_t       px_out,
  output logic         last_out
);

  pixel_t px_next;

  always_comb begin
    logic [DIV9_IN_W+RECIP_W-1:0] prod;
    sum_t scaled;
    for (int c = 0; c < CHANNELS; c++) begin
      // A smooth sum is never negative, so its low bits hold it whole.
      prod = (DIV9_IN_W+RECIP_W)'(sums[c][DIV9_IN_W-1:0]) *
             (DIV9_IN_W+RECIP_W)'(RECIP_NINE);
      if (sel == FILT_SMOOTH) begin
        scaled = sum_t'(prod >> DIV_SHIFT);
      end else begin
        scaled = sums[c];
      end
      if (scaled < 0) begin
        px_next[CHAN_W*c +: CHAN_W] = '0;
      end else if (scaled > sum_t'(CHAN_MAX)) begin
        px_next[CHAN_W*c +: CHAN_W] = CHAN_W'(CHAN_MAX);
      end else begin
        px_next[CHAN_W*c +: CHAN_W] = scaled[CHAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_out   <= px_next;
      last_out <= last;
    end
  end

endmodule

`default_nettype wire

FILE: design/conv3x3_rgb_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Handshake            Payload
// pixel in    input      in_valid / in_stall  in_blue, in_green, in_red, frame_start
// pixel out   output     out_valid / out_stall out_blue, out_green, out_red, frame_last
// config      input      APB psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One pixel beat is taken every clock while in_stall is low. The pixel that completes
// a window passes the line buffer read, channel sums and output register in turn.
// Reset (rst, synchronous) clears the counters, the pipeline valid bits and the
// registers to smooth, 640 by 480. The line buffers are not cleared.
// An out_stall backs up through the three pipeline registers; in_stall rises only
// when the input register is full and cannot move on.
module conv3x3_rgb_filter import c3f_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_red,
  input  wire logic        frame_start,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_green,
  output logic [7:0]       out_red,
  output logic             frame_last,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Counter widths follow the largest frame; comparisons run wide enough to hold
  // both the 12-bit register and the largest dimension itself.
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WCMP = (CW + 1 > CFG_DIM_W) ? CW + 1 : CFG_DIM_W;
  localparam int HCMP = (RW + 1 > CFG_DIM_W) ? RW + 1 : CFG_DIM_W;

  // Configuration registers.
  logic [2:0]           filter_select;
  logic [CFG_DIM_W-1:0] image_width;
  logic [CFG_DIM_W-1:0] image_height;

  logic cfg_write;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_select <= FILT_SMOOTH;
      image_width   <= CFG_DIM_W'(640);
      image_height  <= CFG_DIM_W'(480);
    end else if (cfg_write) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_FILTER: filter_select <= pwdata[2:0];
        REG_WIDTH:  image_width   <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: image_height  <= pwdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_FILTER: prdata = 32'(filter_select);
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  // Effective settings: codes above outline act as outline, and the dimensions
  // are held to 3..MAX.
  filter_t          sel_eff;
  logic [WCMP-1:0]  w_raw, w_eff;
  logic [HCMP-1:0]  h_raw, h_eff;

  always_comb begin
    sel_eff = (filter_select > FILT_OUTLINE) ? FILT_OUTLINE : filter_t'(filter_select);
    w_raw   = WCMP'(image_width);
    h_raw   = HCMP'(image_height);
    if (w_raw < WCMP'(MIN_DIM)) begin
      w_eff = WCMP'(MIN_DIM);
    end else if (w_raw > WCMP'(MAX_WIDTH)) begin
      w_eff = WCMP'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < HCMP'(MIN_DIM)) begin
      h_eff = HCMP'(MIN_DIM);
    end else if (h_raw > HCMP'(MAX_HEIGHT)) begin
      h_eff = HCMP'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // Pipeline control. Stage A holds the accepted pixel while its line buffer read
  // completes; stage B holds the channel sums; the output register holds the beat.
  logic valid_a, valid_b;
  logic adv_a, adv_b, accept;
  logic emit_a, last_a, last_b;

  always_comb begin
    adv_b    = valid_b && (!out_valid || !out_stall);
    // A pixel that makes no result only shifts the window, so it never waits on B.
    adv_a    = valid_a && (!emit_a || !valid_b || adv_b);
    in_stall = valid_a && !adv_a;
    accept   = in_valid && !in_stall;
  end

  // Raster counters, with frame_start taking effect before the pixel is placed.
  logic [CW-1:0]   column_count, column_count_next, cc;
  logic [RW-1:0]   row_count, row_count_next, rr;
  logic [WCMP-1:0] cc_inc;
  logic [HCMP-1:0] rr_inc;
  logic            emit_new, last_new;

  always_comb begin
    cc     = frame_start ? '0 : column_count;
    rr     = frame_start ? '0 : row_count;
    cc_inc = WCMP'(cc) + WCMP'(1);
    rr_inc = HCMP'(rr) + HCMP'(1);
    emit_new = (cc >= CW'(WIN_SIZE - 1)) && (rr >= RW'(WIN_SIZE - 1));
    last_new = (WCMP'(cc) == w_eff - WCMP'(1)) && (HCMP'(rr) == h_eff - HCMP'(1));
    if (cc_inc >= w_eff) begin
      column_count_next = '0;
      row_count_next    = (rr_inc >= h_eff) ? '0 : rr_inc[RW-1:0];
    end else begin
      column_count_next = cc_inc[CW-1:0];
      row_count_next    = rr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Stage A payload. When the pixel in A writes the same column that the new pixel
  // reads in the same cycle (a frame restart at column zero right after column
  // zero), the written data is kept aside and replaces the stale read.
  pixel_t        px_a, up1_a, up2_a, fwd_up1, fwd_up2;
  logic [CW-1:0] col_a;
  logic          hit_a;
  pixel_t        rd_up1, rd_up2;

  always_ff @(posedge clk) begin
    if (accept) begin
      px_a    <= {in_red, in_green, in_blue};
      col_a   <= cc;
      emit_a  <= emit_new;
      last_a  <= last_new;
      hit_a   <= valid_a && (col_a == cc);
      fwd_up1 <= px_a;
      fwd_up2 <= up1_a;
    end
  end

  assign up1_a = hit_a ? fwd_up1 : rd_up1;
  assign up2_a = hit_a ? fwd_up2 : rd_up2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        valid_a <= 1'b1;
      end else if (adv_a) begin
        valid_a <= 1'b0;
      end
      if (adv_a && emit_a) begin
        valid_b <= 1'b1;
      end else if (adv_b) begin
        valid_b <= 1'b0;
      end
      if (adv_b) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && emit_a) begin
      last_b <= last_a;
    end
  end

  c3f_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (cc),
    .wr_en   (adv_a),
    .wr_addr (col_a),
    .wr_up1  (px_a),
    .wr_up2  (up1_a),
    .rd_up1  (rd_up1),
    .rd_up2  (rd_up2)
  );

  sum_t sums_b [CHANNELS];

  c3f_window u_window (
    .clk      (clk),
    .shift_en (adv_a),
    .load_en  (adv_a && emit_a),
    .px       (px_a),
    .up1      (up1_a),
    .up2      (up2_a),
    .sel      (sel_eff),
    .sums     (sums_b)
  );

  pixel_t px_out;

  c3f_post u_post (
    .clk      (clk),
    .load     (adv_b),
    .sel      (sel_eff),
    .sums     (sums_b),
    .last     (last_b),
    .px_out   (px_out),
    .last_out (frame_last)
  );

  assign out_blue  = px_out[7:0];
  assign out_green = px_out[15:8];
  assign out_red   = px_out[23:16];

  // A new pixel is only taken while the pixel in stage A is leaving.
  a_accept_moves_a: assert property (@(posedge clk) disable iff (rst)
    (accept && valid_a) |-> adv_a)
    else $error("pixel accepted over an occupied stage A");

  // The last pixel of a frame always completes a full window.
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (valid_a && last_a) |-> emit_a)
    else $error("frame end marked on a pixel without a result");

  // Sums leaving stage B always show up as an output beat.
  a_b_to_out: assert property (@(posedge clk) disable iff (rst)
    adv_b |=> out_valid)
    else $error("stage B moved without an output beat");

endmodule

`default_nettype wire

FILE: verif/conv3x3_rgb_filter_test.sv
`timescale 1ns / 1ps

module conv3x3_rgb_filter_test;
  import c3f_pkg::*;

  // Line buffer depth and row limit the block is built with.
  localparam int LINE_MAX = 2048;
  localparam int ROW_MAX  = 2048;

  localparam int RESET_CYCLES = 10;
  // Lets pixel beats that make no result flush out of the pipeline after
  // the last filtered beat has come out.
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 320;
  localparam int CYCLE_LIMIT   = 1000000;

  // The long receiver hold-off: first after a few dozen result beats, then
  // again every so often, so that the block backs up and stalls its input.
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_FIRST    = 30;
  localparam int HOLD_SPACING  = 1500;

  // Highest filter code that fits the register; codes above outline act as
  // outline.
  localparam logic [2:0] FILT_CODE_TOP = 3'd7;

  // Coefficients per kernel. Tap r*3+c weights window row r (oldest row
  // first) and column c (oldest column first).
  localparam int COEFS [FILTER_COUNT][TAPS] = '{
    '{ 1,  1,  1,  1,  1,  1,  1,  1,  1},
    '{ 0, -1,  0, -1,  5, -1,  0, -1,  0},
    '{ 0,  1,  0,  1, -4,  1,  0,  1,  0},
    '{ 2,  1,  0,  1,  1, -1,  0, -1, -2},
    '{-1, -1, -1, -1,  8, -1, -1, -1, -1}
  };

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       start;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } filtered_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_blue = 8'h00;
  logic [7:0]  in_green = 8'h00;
  logic [7:0]  in_red = 8'h00;
  logic        frame_start = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic        frame_last;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // Pixel beats waiting for the driver, and filtered beats the monitor is
  // still waiting for, oldest first.
  pixel_beat_t    pending_pixels[$];
  filtered_beat_t expected_filtered[$];

  int errors = 0;
  int cycle_count = 0;
  int beats_received = 0;

  // The filter's own copy of the registers and of the pixel history.
  logic [2:0]  cfg_filter = FILT_SMOOTH;
  logic [11:0] cfg_width = 12'd640;
  logic [11:0] cfg_height = 12'd480;
  pixel_t      line_prev [LINE_MAX];
  pixel_t      line_prev2 [LINE_MAX];
  pixel_t      window [TAPS];
  int          col_cnt = 0;
  int          row_cnt = 0;

  conv3x3_rgb_filter #(
    .MAX_WIDTH (LINE_MAX),
    .MAX_HEIGHT(ROW_MAX)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_blue    (in_blue),
    .in_green   (in_green),
    .in_red     (in_red),
    .frame_start(frame_start),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_blue   (out_blue),
    .out_green  (out_green),
    .out_red    (out_red),
    .frame_last (frame_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    for (int i = 0; i < LINE_MAX; i++) begin
      line_prev[i] = '0;
      line_prev2[i] = '0;
    end
    for (int i = 0; i < TAPS; i++) begin
      window[i] = '0;
    end
  end

  initial begin
    forever #1 clk = ~clk;
  end

  // Width and height below the minimum act as the minimum, and above the
  // limit (buffer size for width, row limit for height) act as that limit.
  function automatic int clamp_dim(input int value, input int limit);
    if (value < MIN_DIM) return MIN_DIM;
    if (value > limit) return limit;
    return value;
  endfunction

  // Shifts one pixel into the window and line history, and queues the
  // filtered beat it completes, if the whole window lies inside the frame.
  task automatic convolve_pixel(input pixel_beat_t beat);
    int w;
    int h;
    int col;
    int r;
    int ch;
    int tap;
    int acc;
    filter_t kern;
    pixel_t above1;
    pixel_t above2;
    logic [7:0] chan [CHANNELS];
    filtered_beat_t res;

    w = clamp_dim(cfg_width, LINE_MAX);
    h = clamp_dim(cfg_height, ROW_MAX);
    kern = (cfg_filter > FILT_OUTLINE) ? FILT_OUTLINE : filter_t'(cfg_filter);

    if (beat.start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = col_cnt % LINE_MAX;
    above1 = line_prev[col];
    above2 = line_prev2[col];

    for (r = 0; r < WIN_SIZE; r++) begin
      window[r*3]   = window[r*3+1];
      window[r*3+1] = window[r*3+2];
    end
    window[2] = above2;
    window[5] = above1;
    window[8] = {beat.red, beat.green, beat.blue};

    line_prev2[col] = above1;
    line_prev[col] = {beat.red, beat.green, beat.blue};

    if (row_cnt >= 2 && col_cnt >= 2) begin
      for (ch = 0; ch < CHANNELS; ch++) begin
        acc = 0;
        for (tap = 0; tap < TAPS; tap++) begin
          acc += int'(window[tap][CHAN_W*ch +: CHAN_W]) * COEFS[kern][tap];
        end
        // Integer division truncates toward zero, as the block does.
        acc = acc / ((kern == FILT_SMOOTH) ? 9 : 1);
        chan[ch] = (acc > CHAN_MAX) ? 8'(CHAN_MAX) : (acc < 0) ? 8'd0 : 8'(acc);
      end
      res.blue  = chan[0];
      res.green = chan[1];
      res.red   = chan[2];
      res.last  = (row_cnt == h - 1) && (col_cnt == w - 1);
      expected_filtered.push_back(res);
    end

    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endtask

  // Register write: the setup phase, then the access phase; the write
  // lands at the edge where pready is seen high.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FILTER: cfg_filter = value[2:0];
      REG_WIDTH:  cfg_width  = value[11:0];
      REG_HEIGHT: cfg_height = value[11:0];
      default: ;
    endcase
  endtask

  // Waits until every pixel beat has gone in and every filtered beat has
  // come out, then lets the pipeline settle before registers change.
  task automatic drain_pipeline();
    while (pending_pixels.size() != 0 || in_valid || expected_filtered.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic s);
    pending_pixels.push_back({b, g, r, s});
  endtask

  // Channel values lean on the extremes so that both clamps get hit often.
  function automatic logic [7:0] channel_value();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Queues a run of random pixels. With noise on, a stray frame start now
  // and then breaks the frame partway through.
  task automatic queue_pixels(input int count, input bit start_first, input bit noisy,
                              output bit restarted);
    int n;
    logic s;

    restarted = 1'b0;
    for (n = 0; n < count; n++) begin
      s = (n == 0) ? start_first : (noisy && $urandom_range(0, 39) == 0);
      if (n != 0 && s) restarted = 1'b1;
      push_pixel(channel_value(), channel_value(), channel_value(), s);
    end
  endtask

  // Driver. A pixel beat moves at an edge where in_valid is high and
  // in_stall is low; the model is stepped right there. The next beat is only
  // put up once the current one has moved, so a stalled beat holds still.
  // The sender works in bursts with gaps of random length between them.
  pixel_beat_t shown_beat = '0;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        convolve_pixel(shown_beat);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || pending_pixels.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          shown_beat = pending_pixels.pop_front();
          in_blue     <= shown_beat.blue;
          in_green    <= shown_beat.green;
          in_red      <= shown_beat.red;
          frame_start <= shown_beat.start;
          in_valid    <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            // A third of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
    end
  end

  // Receiver stall. The stall density is redrawn at random, from none at
  // all up to heavy. Every so often the receiver holds off for a long
  // stretch while the sender keeps offering pixel beats.
  int stall_cycle = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int next_hold_at = HOLD_FIRST;

  always @(posedge clk) begin
    stall_cycle++;
    if (stall_cycle % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    if (hold_left == 0 && beats_received >= next_hold_at) begin
      hold_left = HOLD_CYCLES;
      next_hold_at += HOLD_SPACING;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor. Every filtered beat that moves is checked against the oldest
  // expected one, field by field.
  always @(posedge clk) begin
    filtered_beat_t want;

    if (!rst && out_valid === 1'b1 && !out_stall) begin
      beats_received++;
      if (expected_filtered.size() == 0) begin
        errors++;
        $error("filtered beat with nothing expected: blue %0d green %0d red %0d last %0b",
               out_blue, out_green, out_red, frame_last);
      end else begin
        want = expected_filtered.pop_front();
        if (out_blue !== want.blue) begin
          errors++;
          $error("out_blue: expected %0d, actual %0d", want.blue, out_blue);
        end
        if (out_green !== want.green) begin
          errors++;
          $error("out_green: expected %0d, actual %0d", want.green, out_green);
        end
        if (out_red !== want.red) begin
          errors++;
          $error("out_red: expected %0d, actual %0d", want.red, out_red);
        end
        if (frame_last !== want.last) begin
          errors++;
          $error("frame_last: expected %0b, actual %0b", want.last, frame_last);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("conv3x3_rgb_filter_test: errors");
      $finish;
    end
  end

  initial begin
    int phase_no;
    int rotate;
    int code;
    int wval;
    int hval;
    int eff_w;
    int eff_h;
    int full;
    int count;
    int nframes;
    int f;
    int random_beats;
    bit aligned;
    bit restarted;
    bit start;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Smallest frame, outline kernel: one result. Blue has a lone bright
    // center and saturates high, green has a dark center among bright
    // neighbors and saturates low, and flat red cancels to zero.
    write_reg(REG_FILTER, FILT_OUTLINE);
    write_reg(REG_WIDTH, MIN_DIM);
    write_reg(REG_HEIGHT, MIN_DIM);
    for (int i = 0; i < TAPS; i++) begin
      push_pixel((i == 4) ? 8'hFF : 8'h00, (i == 4) ? 8'h00 : 8'hFF, 8'h80, i == 0);
    end
    drain_pipeline();

    // Smooth over a full-scale blue window lands exactly on the top value;
    // red sums to 46, so the division by nine has to truncate.
    write_reg(REG_FILTER, FILT_SMOOTH);
    for (int i = 0; i < TAPS; i++) begin
      push_pixel(8'hFF, 8'h00, 8'(i + 1 + (i == 4)), i == 0);
    end
    drain_pipeline();

    // Filter code past outline, then both bounds lowered under the running
    // counters in mid-frame. The pause lands at column 7 of row 4 in an 8 by
    // 10 frame; width 5 and height 4 then put both counters past their
    // bounds. The next pixel still filters, without marking the frame end,
    // and then both counters wrap so a 5 by 4 frame follows with no frame
    // start at all.
    write_reg(REG_FILTER, FILT_CODE_TOP);
    write_reg(REG_WIDTH, 8);
    write_reg(REG_HEIGHT, 10);
    queue_pixels(4 * 8 + 7, 1'b1, 1'b0, restarted);
    drain_pipeline();
    write_reg(REG_WIDTH, 5);
    write_reg(REG_HEIGHT, 4);
    queue_pixels(1 + 5 * 4, 1'b0, 1'b0, restarted);
    drain_pipeline();

    // Random phases: small frames, every filter code in turn, now and then a
    // width or height under the minimum. Most frames are whole; some are cut
    // short or broken by a stray frame start, and a whole frame may be
    // followed by one that simply carries on without a frame start.
    rotate = $urandom_range(0, 7);
    phase_no = 0;
    random_beats = 0;
    while (random_beats < RANDOM_ITEMS || phase_no < 8) begin
      code = (phase_no + rotate) % 8;
      wval = $urandom_range(MIN_DIM, 8);
      hval = $urandom_range(MIN_DIM, 6);
      if ($urandom_range(0, 7) == 0) wval = $urandom_range(0, MIN_DIM - 1);
      if ($urandom_range(0, 7) == 0) hval = $urandom_range(0, MIN_DIM - 1);
      eff_w = clamp_dim(wval, LINE_MAX);
      eff_h = clamp_dim(hval, ROW_MAX);
      // Bits above each register's width carry noise and must be ignored.
      write_reg(REG_FILTER, ($urandom() & ~32'h7) | code);
      write_reg(REG_WIDTH, ($urandom() & ~32'hFFF) | wval);
      write_reg(REG_HEIGHT, ($urandom() & ~32'hFFF) | hval);
      full = eff_w * eff_h;
      nframes = $urandom_range(1, 3);
      aligned = 1'b0;
      for (f = 0; f < nframes; f++) begin
        start = !aligned || ($urandom_range(0, 1) == 0);
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(1, full - 1) : full;
        queue_pixels(count, start, $urandom_range(0, 3) == 0, restarted);
        aligned = (count == full) && !restarted;
        random_beats += count;
      end
      drain_pipeline();
      phase_no++;
    end

    if (errors == 0) begin
      $display("conv3x3_rgb_filter_test: clean");
    end else begin
      $display("conv3x3_rgb_filter_test: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
design/c3f_pkg.sv
design/c3f_line_buf.sv
design/c3f_window.sv
design/c3f_post.sv
design/conv3x3_rgb_filter.sv
verif/conv3x3_rgb_filter_test.sv
